// File: rtl/ccb_pkg.sv
// Shared constants for the circular coverage bounds block.
package ccb_pkg;

	localparam int unsigned OUT_W      = 13;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned BIT_IDX_W  = 5;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_BIT   = 1'b0,
		REG_WRAP_ENABLE = 1'b1
	} cfg_reg_t;

endpackage

// File: rtl/ccb_column_if.sv
// Column word channel: one coverage word per column.
interface ccb_column_if import ccb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] column_word;
	logic              last_column;

	modport source (output valid, output column_word, output last_column, input ready);
	modport sink (input valid, input column_word, input last_column, output ready);
endinterface

// File: rtl/ccb_bounds_if.sv
// Result channel: covering interval of one row.
interface ccb_bounds_if import ccb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             any_set;
	logic [OUT_W-1:0] lower_bound;
	logic [OUT_W-1:0] upper_bound;
	logic [OUT_W-1:0] gap_length;
	logic             too_long;

	modport source (output valid, output any_set, output lower_bound, output upper_bound,
		output gap_length, output too_long, input ready);
	modport sink (input valid, input any_set, input lower_bound, input upper_bound,
		input gap_length, input too_long, output ready);
endinterface

// File: rtl/ccb_cfg_if.sv
// Configuration write channel: register index and write data.
interface ccb_cfg_if import ccb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/circular_coverage_bounds_unit.sv
// Top level of the circular coverage bounds block.
//
// Columns of one row arrive on the columns channel, one word per column,
// with last_column marking the final column. Each word is tested at the
// configured image_bit. After the last column one word leaves on the
// bounds channel: the covering interval, the largest clear gap when
// wrap_enable is set, and the too_long flag when the row ran past
// MAX_WIDTH columns (extra columns are dropped, the marked last column
// still closes the row).
// Registers are written on the cfg channel (index 0 image_bit, index 1
// wrap_enable); the user must write them only while the block is idle,
// which the block itself does not enforce; cfg is always ready. One
// column per cycle, except that a last column waits while the snapshot
// stage is full. The last column passes the input register, then
// snapshot, gap select and output stages to the result word.
// Up to three results are held when bounds stalls; columns keep flowing
// until a fourth row end finds no room. Reset clears the row state, the
// pipeline valids and both registers.
module circular_coverage_bounds_unit import ccb_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 8192
) (
	input  logic         clk,
	input  logic         arst_n,
	ccb_column_if.sink   columns,
	ccb_bounds_if.source bounds,
	ccb_cfg_if.sink      cfg
);

	localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);

	logic [BIT_IDX_W-1:0] image_bit_q;
	logic                 wrap_enable_q;

	logic                 snap_valid;
	logic                 snap_ready;
	logic [CNT_W-1:0]     snap_width;
	logic                 snap_seen;
	logic [CNT_W-1:0]     snap_first;
	logic [CNT_W-1:0]     snap_last;
	logic [CNT_W-1:0]     snap_best_len;
	logic [CNT_W-1:0]     snap_best_start;
	logic [CNT_W-1:0]     snap_zrun;
	logic                 snap_ovf;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_bit_q   <= '0;
			wrap_enable_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_BIT:   image_bit_q   <= cfg.data[BIT_IDX_W-1:0];
				REG_WRAP_ENABLE: wrap_enable_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	ccb_row_tracker #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.image_bit       (image_bit_q),
		.col             (columns),
		.snap_valid      (snap_valid),
		.snap_ready      (snap_ready),
		.snap_width      (snap_width),
		.snap_seen       (snap_seen),
		.snap_first      (snap_first),
		.snap_last       (snap_last),
		.snap_best_len   (snap_best_len),
		.snap_best_start (snap_best_start),
		.snap_zrun       (snap_zrun),
		.snap_ovf        (snap_ovf)
	);

	ccb_finalize #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_finalize (
		.clk             (clk),
		.arst_n          (arst_n),
		.wrap_enable     (wrap_enable_q),
		.snap_valid      (snap_valid),
		.snap_ready      (snap_ready),
		.snap_width      (snap_width),
		.snap_seen       (snap_seen),
		.snap_first      (snap_first),
		.snap_last       (snap_last),
		.snap_best_len   (snap_best_len),
		.snap_best_start (snap_best_start),
		.snap_zrun       (snap_zrun),
		.snap_ovf        (snap_ovf),
		.res             (bounds)
	);

endmodule

// File: rtl/ccb_row_tracker.sv
// Per-row tracking of set columns and clear runs, with end-of-row snapshot.
module ccb_row_tracker import ccb_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 8192,
	localparam int unsigned CNT_W    = $clog2(MAX_WIDTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [BIT_IDX_W-1:0] image_bit,
	ccb_column_if.sink           col,
	output logic                 snap_valid,
	input  logic                 snap_ready,
	output logic [CNT_W-1:0]     snap_width,
	output logic                 snap_seen,
	output logic [CNT_W-1:0]     snap_first,
	output logic [CNT_W-1:0]     snap_last,
	output logic [CNT_W-1:0]     snap_best_len,
	output logic [CNT_W-1:0]     snap_best_start,
	output logic [CNT_W-1:0]     snap_zrun,
	output logic                 snap_ovf
);

	logic             valid_s1;
	logic             bit_s1;
	logic             last_s1;
	logic             valid_s2;

	logic [CNT_W-1:0] pos_q, first_q, last_q, best_len_q, best_start_q, zrun_q;
	logic             seen_q, ovf_q;

	logic [CNT_W-1:0] pos_n, first_n, last_n, best_len_n, best_start_n, zrun_n;
	logic             seen_n, ovf_n;

	logic             s2_free;
	logic             s1_go;
	logic             row_end;

	assign s2_free    = !valid_s2 || snap_ready;
	assign s1_go      = valid_s1 && (!last_s1 || s2_free);
	assign row_end    = s1_go && last_s1;
	assign col.ready  = !valid_s1 || s1_go;
	assign snap_valid = valid_s2;

	always_comb begin
		pos_n        = pos_q;
		seen_n       = seen_q;
		first_n      = first_q;
		last_n       = last_q;
		best_len_n   = best_len_q;
		best_start_n = best_start_q;
		zrun_n       = zrun_q;
		ovf_n        = ovf_q;
		if (pos_q == CNT_W'(MAX_WIDTH)) begin
			ovf_n = 1'b1;
		end else begin
			if (bit_s1) begin
				if (!seen_q) begin
					seen_n  = 1'b1;
					first_n = pos_q;
				end else if (zrun_q > best_len_q) begin
					best_len_n   = zrun_q;
					best_start_n = pos_q - zrun_q;
				end
				last_n = pos_q;
				zrun_n = '0;
			end else if (seen_q) begin
				zrun_n = zrun_q + 1'b1;
			end
			pos_n = pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (col.ready) begin
				valid_s1 <= col.valid;
			end
			if (s2_free) begin
				valid_s2 <= row_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (col.ready) begin
			bit_s1  <= col.column_word[image_bit];
			last_s1 <= col.last_column;
		end
		if (s2_free && row_end) begin
			snap_width      <= pos_n;
			snap_seen       <= seen_n;
			snap_first      <= first_n;
			snap_last       <= last_n;
			snap_best_len   <= best_len_n;
			snap_best_start <= best_start_n;
			snap_zrun       <= zrun_n;
			snap_ovf        <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			seen_q       <= 1'b0;
			first_q      <= '0;
			last_q       <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			zrun_q       <= '0;
			ovf_q        <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				pos_q        <= '0;
				seen_q       <= 1'b0;
				first_q      <= '0;
				last_q       <= '0;
				best_len_q   <= '0;
				best_start_q <= '0;
				zrun_q       <= '0;
				ovf_q        <= 1'b0;
			end else begin
				pos_q        <= pos_n;
				seen_q       <= seen_n;
				first_q      <= first_n;
				last_q       <= last_n;
				best_len_q   <= best_len_n;
				best_start_q <= best_start_n;
				zrun_q       <= zrun_n;
				ovf_q        <= ovf_n;
			end
		end
	end

endmodule

// File: rtl/ccb_finalize.sv
// Gap selection and interval computation for one finished row.
module ccb_finalize import ccb_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 8192,
	localparam int unsigned CNT_W    = $clog2(MAX_WIDTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wrap_enable,
	input  logic             snap_valid,
	output logic             snap_ready,
	input  logic [CNT_W-1:0] snap_width,
	input  logic             snap_seen,
	input  logic [CNT_W-1:0] snap_first,
	input  logic [CNT_W-1:0] snap_last,
	input  logic [CNT_W-1:0] snap_best_len,
	input  logic [CNT_W-1:0] snap_best_start,
	input  logic [CNT_W-1:0] snap_zrun,
	input  logic             snap_ovf,
	ccb_bounds_if.source     res
);

	logic             valid_s3;
	logic [CNT_W-1:0] width_s3, first_s3, last_s3, len_s3, start_s3;
	logic             any_s3, wrap_s3, ovf_s3;

	logic             valid_q;
	logic             out_free;
	logic             s3_free;

	logic [CNT_W:0]   wrap_len;
	logic             take_wrap;
	logic [CNT_W-1:0] last_plus;
	logic [CNT_W-1:0] len_sel, start_sel;

	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] lo_n, hi_n, gap_n;

	assign out_free   = !valid_q || res.ready;
	assign s3_free    = !valid_s3 || out_free;
	assign snap_ready = s3_free;
	assign res.valid  = valid_q;

	always_comb begin
		wrap_len  = {1'b0, snap_zrun} + {1'b0, snap_first};
		take_wrap = wrap_len > {1'b0, snap_best_len};
		last_plus = snap_last + 1'b1;
		if (take_wrap) begin
			len_sel   = wrap_len[CNT_W-1:0];
			start_sel = (last_plus >= snap_width) ? '0 : last_plus;
		end else begin
			len_sel   = snap_best_len;
			start_sel = snap_best_start;
		end
	end

	always_comb begin
		sum   = {1'b0, start_s3} + {1'b0, len_s3};
		lo_n  = '0;
		hi_n  = '0;
		gap_n = '0;
		if (any_s3) begin
			if (!wrap_s3) begin
				lo_n = first_s3;
				hi_n = last_s3;
			end else if (len_s3 == '0) begin
				hi_n = width_s3 - 1'b1;
			end else begin
				if (sum >= {1'b0, width_s3}) begin
					sum = sum - {1'b0, width_s3};
				end
				lo_n  = sum[CNT_W-1:0];
				hi_n  = (start_s3 == '0) ? (width_s3 - 1'b1) : (start_s3 - 1'b1);
				gap_n = len_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s3_free) begin
				valid_s3 <= snap_valid;
			end
			if (out_free) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && snap_valid) begin
			width_s3 <= snap_width;
			first_s3 <= snap_first;
			last_s3  <= snap_last;
			len_s3   <= len_sel;
			start_s3 <= start_sel;
			any_s3   <= snap_seen;
			wrap_s3  <= wrap_enable;
			ovf_s3   <= snap_ovf;
		end
		if (out_free && valid_s3) begin
			res.any_set     <= any_s3;
			res.lower_bound <= OUT_W'(lo_n);
			res.upper_bound <= OUT_W'(hi_n);
			res.gap_length  <= OUT_W'(gap_n);
			res.too_long    <= ovf_s3;
		end
	end

endmodule
